// ===== design/ppurs_pkg.sv =====
// Package: request codes, register numbers, address constants and scroll helpers.
`default_nettype none

package ppurs_pkg;

  localparam int ADDR_W = 15;
  localparam int OAM_PTR_W = 8;

  localparam logic [3:0] MODE_READ      = 4'd0;
  localparam logic [3:0] MODE_WRITE     = 4'd1;
  localparam logic [3:0] MODE_DMA_START = 4'd2;
  localparam logic [3:0] MODE_DMA_BYTE  = 4'd3;
  localparam logic [3:0] MODE_INC_X     = 4'd4;
  localparam logic [3:0] MODE_INC_Y     = 4'd5;
  localparam logic [3:0] MODE_COPY_X    = 4'd6;
  localparam logic [3:0] MODE_COPY_Y    = 4'd7;
  localparam logic [3:0] MODE_FRAME     = 4'd8;
  localparam logic [3:0] MODE_VBLANK    = 4'd9;
  localparam logic [3:0] MODE_SPRITE0   = 4'd10;
  localparam logic [3:0] MODE_OVERFLOW  = 4'd11;

  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDRESS  = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [ADDR_W-1:0] PALETTE_BASE = 15'h3F00;
  localparam logic [ADDR_W-1:0] ROW_STRIDE   = 15'd32;
  localparam logic [ADDR_W-1:0] COL_STRIDE   = 15'd1;

  localparam logic [4:0] ROW_LAST_VISIBLE = 5'd29;
  localparam logic [4:0] ROW_LAST         = 5'd31;
  localparam logic [4:0] COL_LAST         = 5'd31;
  localparam logic [2:0] FINE_Y_LAST      = 3'b111;

  typedef struct packed {
    logic                 en;
    logic [OAM_PTR_W-1:0] addr;
    logic [7:0]           data;
  } oam_wr_t;

  function automatic logic [ADDR_W-1:0] step_x(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if (a[4:0] == COL_LAST) begin
      r = {a[14:11], ~a[10], a[9:5], 5'd0};
    end else begin
      r = {a[14:5], a[4:0] + 5'd1};
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] step_y(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if (a[14:12] != FINE_Y_LAST) begin
      r = {a[14:12] + 3'd1, a[11:0]};
    end else if (a[9:5] == ROW_LAST_VISIBLE) begin
      r = {3'd0, ~a[11], a[10], 5'd0, a[4:0]};
    end else if (a[9:5] == ROW_LAST) begin
      r = {3'd0, a[11:10], 5'd0, a[4:0]};
    end else begin
      r = {3'd0, a[11:10], a[9:5] + 5'd1, a[4:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ppu_register_port_scroll_core.sv =====
// Top level: register port, scroll address update and status flags of the picture unit.
//
//   channel   signals                                          direction  timing
//   request   start, busy, mode, reg_index, write_data,        in         start && !busy
//             vram_read_data
//   result    done, read_data, mem_addr, mem_read, mem_write,  out        done, one cycle
//             nmi_pulse, scroll_addr, fine_scroll_x
//
// One request per cycle while busy is low; its result passes the input and result registers.
// The input register and the result register bound one pass of bit-field logic.
// Sprite memory reads come from a registered port kept at the live OAM pointer.
// Reset clears the control, scroll, pointer and flag state, done and the sprite memory view;
// busy is high only during reset and the cycle after. The result side cannot stall.
`default_nettype none

module ppu_register_port_scroll_core
  import ppurs_pkg::*;
#(
  parameter int SPRITE_MEM_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [3:0]        mode,
  input  wire logic [2:0]        reg_index,
  input  wire logic [7:0]        write_data,
  input  wire logic [7:0]        vram_read_data,
  output logic                   done,
  output logic [7:0]             read_data,
  output logic [ADDR_W-1:0]      mem_addr,
  output logic                   mem_read,
  output logic                   mem_write,
  output logic                   nmi_pulse,
  output logic [ADDR_W-1:0]      scroll_addr,
  output logic [2:0]             fine_scroll_x
);

  logic init;

  logic       req_valid;
  logic [3:0] req_mode;
  logic [2:0] req_reg;
  logic [7:0] req_wd;
  logic [7:0] req_vd;

  logic [ADDR_W-1:0]    cur_addr, cur_addr_next;
  logic [ADDR_W-1:0]    tmp_addr, tmp_addr_next;
  logic [2:0]           fine_x, fine_x_next;
  logic                 write_toggle, write_toggle_next;
  logic [7:0]           read_buffer, read_buffer_next;
  logic [7:0]           control_reg, control_reg_next;
  logic [7:0]           mask_reg, mask_reg_next;
  logic [OAM_PTR_W-1:0] oam_pointer, oam_pointer_next;
  logic [2:0]           status_flags, status_flags_next;

  logic [7:0]        rdata;
  logic [ADDR_W-1:0] maddr;
  logic              mrd;
  logic              mwr;
  logic              nmi;
  oam_wr_t           oam_wr;
  logic [7:0]        oam_rd_data;

  logic              render_on;
  logic [ADDR_W-1:0] data_adv;

  assign busy = rst || init;

  always_ff @(posedge clk) begin
    if (rst) begin
      init      <= 1'b1;
      req_valid <= 1'b0;
    end else begin
      init      <= 1'b0;
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_mode <= mode;
      req_reg  <= reg_index;
      req_wd   <= write_data;
      req_vd   <= vram_read_data;
    end
  end

  assign render_on = |mask_reg[4:3];
  assign data_adv  = cur_addr + (control_reg[2] ? ROW_STRIDE : COL_STRIDE);

  always_comb begin
    cur_addr_next     = cur_addr;
    tmp_addr_next     = tmp_addr;
    fine_x_next       = fine_x;
    write_toggle_next = write_toggle;
    read_buffer_next  = read_buffer;
    control_reg_next  = control_reg;
    mask_reg_next     = mask_reg;
    oam_pointer_next  = oam_pointer;
    status_flags_next = status_flags;
    rdata             = 8'd0;
    maddr             = '0;
    mrd               = 1'b0;
    mwr               = 1'b0;
    nmi               = 1'b0;
    oam_wr.en         = 1'b0;
    oam_wr.addr       = oam_pointer;
    oam_wr.data       = req_wd;
    if (req_valid) begin
      unique case (req_mode)
        MODE_READ: begin
          unique case (req_reg)
            REG_STATUS: begin
              rdata                = {status_flags, 5'd0};
              status_flags_next[2] = 1'b0;
              write_toggle_next    = 1'b0;
            end
            REG_OAM_DATA: begin
              rdata = oam_rd_data;
            end
            REG_DATA: begin
              mrd              = 1'b1;
              maddr            = cur_addr;
              read_buffer_next = req_vd;
              rdata            = (cur_addr >= PALETTE_BASE) ? req_vd : read_buffer;
              cur_addr_next    = data_adv;
            end
            default: begin
            end
          endcase
        end
        MODE_WRITE: begin
          unique case (req_reg)
            REG_CONTROL: begin
              control_reg_next     = req_wd;
              tmp_addr_next[11:10] = req_wd[1:0];
            end
            REG_MASK: begin
              mask_reg_next = req_wd;
            end
            REG_OAM_ADDR: begin
              oam_pointer_next = req_wd;
            end
            REG_OAM_DATA: begin
              oam_wr.en        = 1'b1;
              oam_pointer_next = oam_pointer + 8'd1;
            end
            REG_SCROLL: begin
              if (!write_toggle) begin
                fine_x_next        = req_wd[2:0];
                tmp_addr_next[4:0] = req_wd[7:3];
              end else begin
                tmp_addr_next[14:12] = req_wd[2:0];
                tmp_addr_next[9:5]   = req_wd[7:3];
              end
              write_toggle_next = !write_toggle;
            end
            REG_ADDRESS: begin
              if (!write_toggle) begin
                tmp_addr_next[14:8] = {1'b0, req_wd[5:0]};
              end else begin
                tmp_addr_next[7:0] = req_wd;
                cur_addr_next      = {tmp_addr[14:8], req_wd};
              end
              write_toggle_next = !write_toggle;
            end
            REG_DATA: begin
              mwr           = 1'b1;
              maddr         = cur_addr;
              cur_addr_next = data_adv;
            end
            default: begin
            end
          endcase
        end
        MODE_DMA_START: begin
          oam_pointer_next = '0;
        end
        MODE_DMA_BYTE: begin
          oam_wr.en        = 1'b1;
          oam_pointer_next = oam_pointer + 8'd1;
        end
        MODE_INC_X: begin
          if (render_on) begin
            cur_addr_next = step_x(cur_addr);
          end
        end
        MODE_INC_Y: begin
          if (render_on) begin
            cur_addr_next = step_y(cur_addr);
          end
        end
        MODE_COPY_X: begin
          if (render_on) begin
            cur_addr_next[4:0] = tmp_addr[4:0];
            cur_addr_next[10]  = tmp_addr[10];
          end
        end
        MODE_COPY_Y: begin
          if (render_on) begin
            cur_addr_next[9:5]   = tmp_addr[9:5];
            cur_addr_next[14:11] = tmp_addr[14:11];
          end
        end
        MODE_FRAME: begin
          status_flags_next = 3'd0;
        end
        MODE_VBLANK: begin
          status_flags_next[2] = 1'b1;
          nmi                  = control_reg[7];
        end
        MODE_SPRITE0: begin
          if (&mask_reg[4:3]) begin
            status_flags_next[1] = 1'b1;
          end
        end
        MODE_OVERFLOW: begin
          status_flags_next[0] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  ppurs_oam #(
    .DEPTH (SPRITE_MEM_BYTES)
  ) u_oam (
    .clk     (clk),
    .rst     (rst),
    .wr      (oam_wr),
    .rd_addr (oam_pointer_next),
    .rd_data (oam_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr     <= '0;
      tmp_addr     <= '0;
      fine_x       <= 3'd0;
      write_toggle <= 1'b0;
      read_buffer  <= 8'd0;
      control_reg  <= 8'd0;
      mask_reg     <= 8'd0;
      oam_pointer  <= '0;
      status_flags <= 3'd0;
      done         <= 1'b0;
    end else begin
      cur_addr     <= cur_addr_next;
      tmp_addr     <= tmp_addr_next;
      fine_x       <= fine_x_next;
      write_toggle <= write_toggle_next;
      read_buffer  <= read_buffer_next;
      control_reg  <= control_reg_next;
      mask_reg     <= mask_reg_next;
      oam_pointer  <= oam_pointer_next;
      status_flags <= status_flags_next;
      done         <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      read_data     <= rdata;
      mem_addr      <= maddr;
      mem_read      <= mrd;
      mem_write     <= mwr;
      nmi_pulse     <= nmi;
      scroll_addr   <= cur_addr_next;
      fine_scroll_x <= fine_x_next;
    end
  end

  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req_valid))
    else $error("result strobe without a request in flight");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    done |-> !(mem_read && mem_write))
    else $error("read and write of video memory in one request");

  a_addr_idle: assert property (@(posedge clk) disable iff (rst)
    (done && !mem_read && !mem_write) |-> (mem_addr == '0))
    else $error("memory address reported without an access");

  a_nmi_vblank: assert property (@(posedge clk) disable iff (rst)
    (done && nmi_pulse) |-> status_flags[2])
    else $error("nmi pulse without vblank flag set");

  a_scroll_state: assert property (@(posedge clk) disable iff (rst)
    done |-> (scroll_addr == cur_addr && fine_scroll_x == fine_x))
    else $error("reported scroll address differs from held state");

endmodule

`default_nettype wire

// ===== design/ppurs_oam.sv =====
// Sprite attribute memory: one write port, one registered read port, reset-cleared view.
`default_nettype none

module ppurs_oam
  import ppurs_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire oam_wr_t              wr,
  input  wire logic [OAM_PTR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rd_raw;
  logic             rd_valid;
  logic [AW-1:0]    wa;
  logic [AW-1:0]    ra;
  logic             fwd;

  assign wa  = wr.addr[AW-1:0];
  assign ra  = rd_addr[AW-1:0];
  assign fwd = wr.en && (wa == ra);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.data;
    end
    rd_raw <= fwd ? wr.data : mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wa] <= 1'b1;
      end
      rd_valid <= valid[ra] || fwd;
    end
  end

  assign rd_data = rd_valid ? rd_raw : 8'd0;

endmodule

`default_nettype wire
